>>> rtl/pcc_pkg.sv
`default_nettype none
package pcc_pkg;

	typedef struct packed {
		logic [7:0] ext;
		logic [3:0] n;
		logic [3:0] nr;
		logic [3:0] nl;
		logic [3:0] q1;
		logic [3:0] q2;
		logic [3:0] q3;
		logic [3:0] nj;
	} digits_t;

	typedef struct packed {
		logic signed [12:0] three_charge;
		logic [3:0]         total_spin;
		logic [3:0]         spin_s;
		logic [3:0]         orbital_l;
		logic [6:0]         fundamental_code;
		logic [9:0]         atomic_number;
		logic [9:0]         nucleon_number;
		logic [6:0]         lambda_count;
		logic               code_valid;
		logic               standard_model;
		logic [5:0]         class_flags;
		logic [7:0]         quark_mask;
	} result_t;

	localparam int unsigned DataW = 80;
	localparam logic [31:0] CodeMesonA = 32'd480000000;
	localparam logic [31:0] CodeNegB   = 32'hC4FD_CC80; // -990000000

	function automatic logic signed [3:0] chg_tab(input logic [6:0] i);
		logic signed [3:0] r;
		case (i)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd42, 7'd85, 7'd87: r = -4'sd1;
			7'd2, 7'd4, 7'd6, 7'd8, 7'd84, 7'd86:        r = 4'sd2;
			7'd9:                                         r = 4'sd6;
			7'd11, 7'd13, 7'd15, 7'd17:                   r = -4'sd3;
			7'd24, 7'd34, 7'd37, 7'd44:                   r = 4'sd3;
			default:                                      r = 4'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] spn_tab(input logic [6:0] i);
		logic [2:0] r;
		case (i)
			7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8,
			7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18,
			7'd52:                                        r = 3'd2;
			7'd9, 7'd25, 7'd35, 7'd36, 7'd37, 7'd38, 7'd42,
			7'd45, 7'd46, 7'd51, 7'd54, 7'd56, 7'd57, 7'd58,
			7'd59, 7'd60:                                 r = 3'd1;
			7'd10:                                        r = 3'd4;
			7'd21, 7'd22, 7'd23, 7'd24, 7'd32, 7'd33, 7'd34,
			7'd41, 7'd53, 7'd55, 7'd93:                   r = 3'd3;
			7'd39:                                        r = 3'd5;
			default:                                      r = 3'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pcc_split.sv
`default_nettype none
// stages 1 to 4: magnitude, then shift and add-3 binary to decimal, eight bits a stage
module pcc_split (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] code,
	output pcc_pkg::digits_t dig_s4,
	output logic [31:0]      mag_s4,
	output logic             neg_s4
);
	logic [31:0] mag;
	logic [71:0] conv_s1, conv_s2, conv_s3, conv_s4;
	logic [31:0] mag_s1, mag_s2, mag_s3;
	logic        neg_s1, neg_s2, neg_s3;

	// eight shift steps; decimal digits sit in [71:32], binary part below
	function automatic logic [71:0] dabble8(input logic [71:0] v);
		logic [71:0] w;
		w = v;
		for (int s = 0; s < 8; s++) begin
			for (int k = 0; k < 10; k++) begin
				if (w[32+4*k +: 4] >= 4'd5) w[32+4*k +: 4] = w[32+4*k +: 4] + 4'd3;
			end
			w = {w[70:0], 1'b0};
		end
		return w;
	endfunction

	always_comb begin
		mag = code[31] ? (32'd0 - code) : code;
		dig_s4.nj = conv_s4[35:32];
		dig_s4.q3 = conv_s4[39:36];
		dig_s4.q2 = conv_s4[43:40];
		dig_s4.q1 = conv_s4[47:44];
		dig_s4.nl = conv_s4[51:48];
		dig_s4.nr = conv_s4[55:52];
		dig_s4.n  = conv_s4[59:56];
		// magnitude is at most 2^31, so the part above ten million stays below 215
		dig_s4.ext = 8'(conv_s4[71:68]) * 8'd100 + 8'(conv_s4[67:64]) * 8'd10
			+ 8'(conv_s4[63:60]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			conv_s1 <= dabble8({40'd0, mag});
			mag_s1 <= mag;
			neg_s1 <= code[31];
			conv_s2 <= dabble8(conv_s1);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			conv_s3 <= dabble8(conv_s2);
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			conv_s4 <= dabble8(conv_s3);
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end
endmodule
`default_nettype wire

>>> rtl/pcc_remap.sv
`default_nettype none
// stage 5: digit exceptions
module pcc_remap (
	input  wire logic        clk,
	input  wire logic        en,
	input  pcc_pkg::digits_t dig_s4,
	input  wire logic [31:0] mag_s4,
	input  wire logic        neg_s4,
	output pcc_pkg::digits_t dig_s5,
	output logic [31:0]      mag_s5,
	output logic             neg_s5,
	output logic [7:0]       xb_s5,
	output logic             spec_s5
);
	pcc_pkg::digits_t d;
	logic [7:0] xb;
	logic [3:0] t;
	logic [31:0] raw;

	always_comb begin
		d = dig_s4;
		t = 4'd0;
		raw = neg_s4 ? (32'd0 - mag_s4) : mag_s4;
		xb = dig_s4.ext;
		if (xb == 8'd45 || xb == 8'd46 || xb == 8'd47 || xb == 8'd49) xb = 8'd100;
		if (d.q1 == 4'd9) d.q1 = 4'd0;
		if (d.n == 4'd9 && d.nr == 4'd9) begin
			if (d.nl > 4'd3) begin
				t = d.nl;
				d.nl = d.q3;
				d.q3 = t;
				d.nj = d.q1[0] ? 4'd1 : 4'd3;
				d.q1 = 4'd0;
				d.q2 = t;
			end else if (d.nl != 4'd0) begin
				d.nr = 4'd0;
			end else if (d.q2 == 4'd0 && d.q3 > 4'd2) begin
				d.q3 = 4'd0;
				d.nj = 4'd9;
			end
		end else if (d.n == 4'd4 && d.nr == 4'd9 && d.q2 != 4'd0) begin
			d.q3 = d.q2;
		end else if (mag_s4 == 32'd130 || mag_s4 == 32'd310 || mag_s4 == 32'd150
				|| mag_s4 == 32'd510) begin
			d.nl = 4'd1; d.nj = 4'd1;
		end else if (mag_s4 == 32'd10022 || mag_s4 == 32'd20022) begin
			d.nl = 4'd0;
		end else if (d.ext == 8'd45 || d.ext == 8'd46 || d.ext == 8'd47
				|| d.ext == 8'd49) begin
			d = '0;
			d.ext = 8'd100;
			d.nl = (dig_s4.ext == 8'd47 || dig_s4.ext == 8'd49) ? 4'd2 : 4'd1;
			case (dig_s4.ext)
				8'd45:   d.q3 = 4'd2;
				8'd46:   d.q3 = 4'd3;
				8'd47:   d.q3 = 4'd4;
				default: d.q3 = 4'd3;
			endcase
		end else if (mag_s4 == 32'd30343) begin
			d.q1 = 4'd2; d.q2 = 4'd3; d.q3 = 4'd1;
		end else if (mag_s4 == 32'd30353) begin
			d.q1 = 4'd2; d.q2 = 4'd3; d.q3 = 4'd2;
		end else if (mag_s4 == 32'd30363) begin
			d.q1 = 4'd2; d.q2 = 4'd3; d.q3 = 4'd3;
		end else if (mag_s4 == 32'd1009002) begin
			d.q1 = 4'd0; d.q3 = 4'd2; d.nj = 4'd1;
		end else if (mag_s4 == 32'd1000542) begin
			d.q1 = 4'd5; d.q2 = 4'd5; d.q3 = 4'd5;
		end else if (mag_s4 == 32'd1000522) begin
			d.q1 = 4'd1; d.q2 = 4'd1; d.q3 = 4'd1;
		end else if (mag_s4 == 32'd1000039) begin
			d.n = 4'd9; d.nr = 4'd9; d.q3 = 4'd1; d.nj = 4'd0;
		end else if (mag_s4 == 32'd3100021) begin
			d.q1 = 4'd1; d.q2 = 4'd1; d.q3 = 4'd2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dig_s5 <= d;
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			xb_s5 <= xb;
			spec_s5 <= raw == pcc_pkg::CodeMesonA || raw == pcc_pkg::CodeNegB;
		end
	end
endmodule
`default_nettype wire

>>> rtl/pcc_classify.sv
`default_nettype none
// stage 6: class, nuclear numbers, spins, charge terms
module pcc_classify (
	input  wire logic        clk,
	input  wire logic        en,
	input  pcc_pkg::digits_t dig_s5,
	input  wire logic [31:0] mag_s5,
	input  wire logic        neg_s5,
	input  wire logic [7:0]  xb_s5,
	input  wire logic        spec_s5,
	output pcc_pkg::result_t res_s6
);
	pcc_pkg::digits_t d;
	pcc_pkg::result_t r;
	logic [6:0] fid;
	logic [9:0] z, an;
	logic sm, mes, bar, diq, nuc, lep, qrk, withq;
	logic signed [12:0] ch;
	logic signed [4:0] c1, c2, c3;
	logic [2:0] sp;

	always_comb begin
		d = dig_s5;
		r = '0;
		fid = (d.ext == 8'd0 && d.nl == 4'd0 && d.q1 == 4'd0 && d.q2 == 4'd0)
			? 7'(10 * d.q3 + d.nj) : 7'd0;
		z = 10'(d.n * 100 + d.nr * 10 + d.nl);
		an = 10'(d.q1 * 100 + d.q2 * 10 + d.q3);
		if (xb_s5 < 8'd100) begin
			z = '0; an = '0;
		end
		sm = d.n == 4'd0 || (d.n == 4'd9 && d.nr != 4'd9);
		mes = sm && d.q1 == 4'd0 && d.q2 != 4'd0 && d.q3 != 4'd0 && d.nj != 4'd0
			&& !(neg_s5 && d.q2 == d.q3);
		bar = sm && d.q1 != 4'd0 && d.q2 != 4'd0 && d.q3 != 4'd0 && d.nj != 4'd0;
		diq = sm && d.q1 != 4'd0 && d.q2 != 4'd0 && d.q3 == 4'd0 && d.nj != 4'd0
			&& !(d.nj == 4'd1 && d.q1 == d.q2);
		nuc = xb_s5 >= 8'd100 && z <= an;
		lep = mag_s5 >= 32'd11 && mag_s5 <= 32'd18;
		qrk = mag_s5 >= 32'd1 && mag_s5 <= 32'd8;
		if (xb_s5 != 8'd0) r.code_valid = spec_s5 || nuc;
		else if (mag_s5 < 32'd100 || mes || bar || diq) r.code_valid = 1'b1;
		else r.code_valid = !sm;
		c1 = 5'(pcc_pkg::chg_tab(7'(d.q1)));
		c2 = 5'(pcc_pkg::chg_tab(7'(d.q2)));
		c3 = 5'(pcc_pkg::chg_tab(7'(d.q3)));
		if (nuc) ch = 13'(3 * z);
		else if (fid != 7'd0) ch = 13'(pcc_pkg::chg_tab(fid));
		else if (d.q1 == 4'd0) begin
			ch = 13'(c2 - c3);
			if (ch < 0) ch = -ch;
		end else ch = 13'(c1 + c2 + c3);
		r.three_charge = neg_s5 ? -ch : ch;
		sp = pcc_pkg::spn_tab(fid);
		if (fid != 7'd0)
			r.total_spin = (d.n >= 4'd1 && d.n <= 4'd3) ? 4'(sp[0]) + 4'd1 : 4'(sp);
		else if (nuc) r.total_spin = 4'(d.q3[0]) + 4'd1;
		else r.total_spin = d.nj;
		if (mes && d.n != 4'd9) begin
			if (d.nj == 4'd1) begin
				r.spin_s = d.nl; r.orbital_l = d.nl;
			end else begin
				r.spin_s = (d.nl == 4'd1) ? 4'd0 : 4'd1;
				if (d.nl == 4'd0) r.orbital_l = (d.nj >= 4'd3) ? (d.nj - 4'd3) >> 1 : 4'd0;
				else if (d.nl == 4'd3) r.orbital_l = 4'((5'(d.nj) + 5'd1) >> 1);
				else r.orbital_l = (d.nj - 4'd1) >> 1;
			end
		end
		withq = xb_s5 == 8'd0 && fid == 7'd0;
		for (int q = 1; q <= 8; q++) begin
			r.quark_mask[q-1] = mag_s5 == 32'(q) || (withq && (d.q1 == 4'(q)
				|| d.q2 == 4'(q) || d.q3 == 4'(q)));
		end
		r.fundamental_code = fid;
		r.atomic_number = z;
		r.nucleon_number = an;
		r.lambda_count = (xb_s5 >= 8'd100) ? 7'(xb_s5 - 8'd100) : 7'd0;
		r.standard_model = sm;
		r.class_flags = {qrk, lep, nuc, diq, bar, mes};
	end

	always_ff @(posedge clk) begin
		if (en) res_s6 <= r;
	end
endmodule
`default_nettype wire

>>> rtl/particle_code_classifier_unit.sv
`default_nettype none
// Decodes one signed particle code per beat into charge, spins, nuclear numbers,
// class flags and quark mask. Fully pipelined over six register stages (four for
// the decimal split, then remap and classify): a beat can be accepted every cycle,
// and each beat passes the split, remap and classify registers in turn before
// it reaches m_tdata; backpressure stalls all stages together.
module particle_code_classifier_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // pid_code
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// three_charge, total_spin, spin_s, orbital_l, fundamental_code,
	// atomic_number, nucleon_number, lambda_count, code_valid, standard_model,
	// class_flags, quark_mask (75 bits, zero pad to 80)
	output logic [pcc_pkg::DataW-1:0] m_tdata
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pcc_pkg::digits_t dig_s4, dig_s5;
	logic [31:0] mag_s4, mag_s5;
	logic neg_s4, neg_s5, spec_s5;
	logic [7:0] xb_s5;
	pcc_pkg::result_t res_s6;

	assign en = !v_s6 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	pcc_split u_split (.clk, .en, .code(s_tdata), .dig_s4, .mag_s4, .neg_s4);
	pcc_remap u_remap (.clk, .en, .dig_s4, .mag_s4, .neg_s4,
		.dig_s5, .mag_s5, .neg_s5, .xb_s5, .spec_s5);
	pcc_classify u_cls (.clk, .en, .dig_s5, .mag_s5, .neg_s5, .xb_s5, .spec_s5, .res_s6);

	assign m_tdata = {5'b0, res_s6.quark_mask, res_s6.class_flags, res_s6.standard_model,
		res_s6.code_valid, res_s6.lambda_count, res_s6.nucleon_number,
		res_s6.atomic_number, res_s6.fundamental_code, res_s6.orbital_l,
		res_s6.spin_s, res_s6.total_spin, res_s6.three_charge};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("stalled while output empty");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1) else $error("beat lost at entry");
endmodule
`default_nettype wire

>>> sim/particle_code_classifier_unit_tb.sv
`timescale 1ns / 100ps
module particle_code_classifier_unit_tb;

	localparam int CycleLimit = 300000;
	localparam int PhaseItems = 400;
	localparam int DrainCycles = 12;

	localparam int FlagMeson   = 0;
	localparam int FlagBaryon  = 1;
	localparam int FlagDiquark = 2;
	localparam int FlagNucleus = 3;
	localparam int FlagLepton  = 4;
	localparam int FlagQuark   = 5;

	typedef struct {
		logic [31:0]      code;
		bit               typed;
		pcc_pkg::result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;

	pcc_pkg::result_t expected_results[$];
	stim_row_t        directed_rows[$];
	int               error_count = 0;
	int               cycle_count = 0;
	int               send_idle = 0;
	int               recv_stall = 0;

	int charge3_of[101] = '{
		0, -1, 2, -1, 2, -1, 2, -1, 2, 6, 0,
		-3, 0, -3, 0, -3, 0, -3, 0, 0, 0,
		0, 0, 0, 3, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 3, 0, 0, 3, 0, 0, 0,
		0, -1, 0, 3, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 2, -1, 2, -1, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	int spin_mult_of[101] = '{
		0, 2, 2, 2, 2, 2, 2, 2, 2, 1, 4,
		2, 2, 2, 2, 2, 2, 2, 2, 0, 0,
		3, 3, 3, 3, 1, 0, 0, 0, 0, 0,
		0, 3, 3, 3, 1, 1, 1, 1, 5, 0,
		3, 1, 0, 0, 1, 1, 0, 0, 0, 0,
		1, 2, 3, 1, 3, 1, 1, 1, 1, 1,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 3, 0, 0, 0, 0, 0, 0, 0};

	particle_code_classifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // pid_code
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// three_charge, total_spin, spin_s, orbital_l, fundamental_code, atomic_number,
		// nucleon_number, lambda_count, code_valid, standard_model, class_flags, quark_mask
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	function automatic pcc_pkg::result_t classify_code(input logic [31:0] raw);
		pcc_pkg::result_t r;
		bit neg, sm, mes, bar, diq, nuc, lep, qrk, valid, withq;
		int unsigned mag, xb, ext, n, nr, nl, q1, q2, q3, nj, t;
		int unsigned fid, z, anum, lam, jsp, ssp, lsp, qm;
		int ch;
		neg = raw[31];
		mag = neg ? 32'(-raw) : raw;
		ext = mag / 10000000;
		n = (mag / 1000000) % 10;
		nr = (mag / 100000) % 10;
		nl = (mag / 10000) % 10;
		q1 = (mag / 1000) % 10;
		q2 = (mag / 100) % 10;
		q3 = (mag / 10) % 10;
		nj = mag % 10;
		if (q1 == 9) q1 = 0;
		if (n == 9 && nr == 9) begin
			if (nl > 3) begin
				t = nl; nl = q3; q3 = t;
				nj = (q1 % 2) ? 1 : 3;
				q1 = 0; q2 = q3;
			end else if (nl != 0) begin
				nr = 0;
			end else if (q2 == 0 && q3 > 2) begin
				q3 = 0; nj = 9;
			end
		end else if (n == 4 && nr == 9 && q2 != 0) begin
			q3 = q2;
		end else if (mag == 130 || mag == 310 || mag == 150 || mag == 510) begin
			nl = 1; nj = 1;
		end else if (mag == 10022 || mag == 20022) begin
			nl = 0;
		end else if (ext >= 45 && ext <= 49 && ext != 48) begin
			// old ion codes map onto light nuclei
			n = 0; nr = 0; q1 = 0; q2 = 0; nj = 0; ext = 100;
			case (mag / 10000000)
				45: begin nl = 1; q3 = 2; end
				46: begin nl = 1; q3 = 3; end
				47: begin nl = 2; q3 = 4; end
				default: begin nl = 2; q3 = 3; end
			endcase
		end else if (mag == 30343) begin
			q1 = 2; q2 = 3; q3 = 1;
		end else if (mag == 30353) begin
			q1 = 2; q2 = 3; q3 = 2;
		end else if (mag == 30363) begin
			q1 = 2; q2 = 3; q3 = 3;
		end else if (mag == 1009002) begin
			q1 = 0; q3 = 2; nj = 1;
		end else if (mag == 1000542) begin
			q1 = 5; q2 = 5; q3 = 5;
		end else if (mag == 1000522) begin
			q1 = 1; q2 = 1; q3 = 1;
		end else if (mag == 1000039) begin
			n = 9; nr = 9; q3 = 1; nj = 0;
		end else if (mag == 3100021) begin
			q1 = 1; q2 = 1; q3 = 2;
		end
		xb = mag / 10000000;
		if (xb == 45 || xb == 46 || xb == 47 || xb == 49) xb = 100;
		fid = (ext == 0 && nl + q1 + q2 == 0) ? 10 * q3 + nj : 0;
		z = 0; anum = 0; lam = 0;
		if (xb >= 100) begin
			z = n * 100 + nr * 10 + nl;
			anum = q1 * 100 + q2 * 10 + q3;
			lam = xb - 100;
		end
		sm = n < 1 || (n == 9 && nr != 9);
		mes = sm && q1 == 0 && q2 != 0 && q3 != 0 && nj != 0 && !(neg && q2 == q3);
		bar = sm && q1 != 0 && q2 != 0 && q3 != 0 && nj != 0;
		diq = sm && q1 != 0 && q2 != 0 && q3 == 0 && nj != 0 && !(nj == 1 && q1 == q2);
		nuc = xb >= 100 && z <= anum;
		lep = mag >= 11 && mag <= 18;
		qrk = mag >= 1 && mag <= 8;
		if (xb != 0)
			valid = raw == pcc_pkg::CodeMesonA || raw == pcc_pkg::CodeNegB || nuc;
		else if (mag < 100 || mes || bar || diq)
			valid = 1'b1;
		else
			valid = !sm;
		if (nuc) begin
			ch = 3 * int'(z);
		end else if (fid != 0) begin
			ch = charge3_of[fid];
		end else if (q1 == 0) begin
			ch = charge3_of[q2] - charge3_of[q3];
			if (ch < 0) ch = -ch;
		end else begin
			ch = charge3_of[q3] + charge3_of[q2] + charge3_of[q1];
		end
		if (neg) ch = -ch;
		if (fid != 0)
			jsp = (n >= 1 && n <= 3) ? spin_mult_of[fid] % 2 + 1 : spin_mult_of[fid];
		else if (nuc)
			jsp = q3 % 2 + 1;
		else
			jsp = nj;
		ssp = 0; lsp = 0;
		if (mes && n != 9) begin
			if (nj == 1) begin
				ssp = nl; lsp = nl;
			end else begin
				ssp = (nl == 1) ? 0 : 1;
				// nl 0 with nj 2 has no physical orbital term
				if (nl == 0) lsp = (nj >= 3) ? (nj - 3) / 2 : 0;
				else if (nl == 3) lsp = (nj + 1) / 2;
				else lsp = (nj - 1) / 2;
			end
		end
		withq = xb == 0 && fid == 0;
		qm = 0;
		for (int q = 1; q <= 8; q++)
			if (mag == q || (withq && (q == q1 || q == q2 || q == q3))) qm |= 1 << (q - 1);
		r.three_charge = ch[12:0];
		r.total_spin = jsp[3:0];
		r.spin_s = ssp[3:0];
		r.orbital_l = lsp[3:0];
		r.fundamental_code = fid[6:0];
		r.atomic_number = z[9:0];
		r.nucleon_number = anum[9:0];
		r.lambda_count = lam[6:0];
		r.code_valid = valid;
		r.standard_model = sm;
		r.class_flags = '0;
		r.class_flags[FlagMeson] = mes;
		r.class_flags[FlagBaryon] = bar;
		r.class_flags[FlagDiquark] = diq;
		r.class_flags[FlagNucleus] = nuc;
		r.class_flags[FlagLepton] = lep;
		r.class_flags[FlagQuark] = qrk;
		r.quark_mask = qm[7:0];
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// result beats
	always @(posedge clk) begin
		pcc_pkg::result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
				error_count++;
			end else begin
				e = expected_results.pop_front();
				compare_field("three_charge", 16'(e.three_charge[12:0]),
					16'(m_tdata[12:0]));
				compare_field("total_spin", 16'(e.total_spin), 16'(m_tdata[16:13]));
				compare_field("spin_s", 16'(e.spin_s), 16'(m_tdata[20:17]));
				compare_field("orbital_l", 16'(e.orbital_l), 16'(m_tdata[24:21]));
				compare_field("fundamental_code", 16'(e.fundamental_code),
					16'(m_tdata[31:25]));
				compare_field("atomic_number", 16'(e.atomic_number), 16'(m_tdata[41:32]));
				compare_field("nucleon_number", 16'(e.nucleon_number), 16'(m_tdata[51:42]));
				compare_field("lambda_count", 16'(e.lambda_count), 16'(m_tdata[58:52]));
				compare_field("code_valid", 16'(e.code_valid), 16'(m_tdata[59]));
				compare_field("standard_model", 16'(e.standard_model), 16'(m_tdata[60]));
				compare_field("class_flags", 16'(e.class_flags), 16'(m_tdata[66:61]));
				compare_field("quark_mask", 16'(e.quark_mask), 16'(m_tdata[74:67]));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_code(input logic [31:0] code, input bit typed,
		input pcc_pkg::result_t res);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(typed ? res : classify_code(code));
	endtask

	function automatic logic [31:0] random_code();
		logic [31:0] c;
		int unsigned pick;
		case ($urandom_range(6))
			0: c = $urandom;
			1: c = $urandom_range(99);
			2: c = $urandom_range(9) * 1000000 * ($urandom_range(3) == 0)
				+ $urandom_range(2) * 100000 + $urandom_range(3) * 10000
				+ $urandom_range(9999);
			3: c = 9900000 + $urandom_range(99999);
			4: begin
				// hypernucleus with Z never above A
				pick = $urandom_range(300);
				c = 1000000000 + $urandom_range(113) * 10000000
					+ $urandom_range(pick) * 10000 + pick * 10 + $urandom_range(9);
			end
			5: c = $urandom_range(45, 49) * 10000000 + $urandom_range(9999999);
			default: begin
				case ($urandom_range(9))
					0: c = 130; 1: c = 310; 2: c = 10022; 3: c = 30353;
					4: c = 1009002; 5: c = 1000039; 6: c = 3100021; 7: c = 1000522;
					8: c = 4900000 + $urandom_range(99999);
					default: c = 480000000;
				endcase
			end
		endcase
		if ($urandom_range(1)) c = -c;
		return c;
	endfunction

	initial begin
		logic [31:0] codes[$];
		pcc_pkg::result_t no_res;
		no_res = '0;
		directed_rows.push_back('{32'd0, 1'b1,
			'{code_valid: 1'b1, standard_model: 1'b1, default: '0}});
		directed_rows.push_back('{32'd1, 1'b1,
			'{three_charge: -13'sd1, total_spin: 4'd2, fundamental_code: 7'd1,
			code_valid: 1'b1, standard_model: 1'b1, class_flags: 6'b100000,
			quark_mask: 8'd1, default: '0}});
		codes = '{-32'sd1, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'd11, 32'd21,
			32'd130, 32'd310, 32'd10022, 32'd30343, 32'd1009002, 32'd1000039,
			32'd3100021, 32'd450000000, 32'd490000000, 32'd480000000, pcc_pkg::CodeNegB,
			32'd1000020040, 32'd1000040020, 32'd211, -32'sd111, 32'd112, 32'd2212,
			32'd2101, 32'd9900012};
		foreach (codes[i]) directed_rows.push_back('{codes[i], 1'b0, no_res});
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_code(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].res);
		s_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 78; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 78; end
				default: begin send_idle = 34; recv_stall = 34; end
			endcase
			repeat (PhaseItems) send_code(random_code(), 1'b0, no_res);
		end
		s_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> particle_code_classifier_unit.f
rtl/pcc_pkg.sv
rtl/pcc_split.sv
rtl/pcc_remap.sv
rtl/pcc_classify.sv
rtl/particle_code_classifier_unit.sv
sim/particle_code_classifier_unit_tb.sv
